@@ sv/svcg_pkg.sv @@
`timescale 1ns / 1ps
package svcg_pkg;
    localparam int MAX_VERTICES_DEF  = 4096;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET = 2'd0,
        REG_GROWTH = 2'd1,
        REG_MAXANG = 2'd2,
        REG_COUNT  = 2'd3
    } cfg_reg_t;

    localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
    localparam logic [63:0] GAIN_BASE   = 64'd652032874;
    localparam logic [63:0] GAIN_TAIL   = 64'd434688583;

    typedef struct packed {
        logic signed [23:0] offset;
        logic signed [23:0] growth;
        logic [23:0]        max_angle;
        logic [12:0]        count;
    } cfg_t;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic [29:0] v;
        unique case (i)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            default: v = (i < 24) ? (30'd1048576 >> (i - 10)) : 30'd0;
        endcase
        return $signed({4'd0, v});
    endfunction
endpackage

@@ sv/svcg_if.sv @@
`timescale 1ns / 1ps
interface svcg_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] vertex_index;
    modport source (output valid, output vertex_index, input ready);
    modport sink (input valid, input vertex_index, output ready);
endinterface

interface svcg_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [16:0]        red_level;
    logic [16:0]        green_level;
    logic [16:0]        blue_level;
    modport source (output valid, output pos_x, output pos_y, output red_level,
                    output green_level, output blue_level, input ready);
    modport sink (input valid, input pos_x, input pos_y, input red_level,
                  input green_level, input blue_level, output ready);
endinterface

@@ sv/svcg_divider.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider: t16 = (idx << 16) / (n - 1), one quotient bit per stage.
module svcg_divider #(
    parameter int NW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [11:0]   idx,
    input  logic [NW-1:0] dvs,
    output logic          out_valid,
    output logic [16:0]   quot
);
    localparam int QB = 28;   // numerator bits (12 + 16)
    logic          v_reg [QB+1];
    logic [QB-1:0] num_reg [QB+1];
    logic [NW:0]   rem_reg [QB+1];
    logic [NW-1:0] d_reg [QB+1];
    logic [QB-1:0] q_reg [QB+1];

    assign num_reg[0] = {idx, 16'd0};
    assign rem_reg[0] = '0;
    assign d_reg[0]   = dvs;
    assign q_reg[0]   = '0;
    assign v_reg[0]   = in_valid;

    for (genvar k = 0; k < QB; k++) begin : g_st
        logic [NW+1:0] tr;
        logic [NW+1:0] df;
        assign tr = {rem_reg[k], num_reg[k][QB-1-k]};
        assign df = tr - {2'b0, d_reg[k]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k+1] <= num_reg[k];
                d_reg[k+1]   <= d_reg[k];
                if (!df[NW+1])
                begin
                    rem_reg[k+1] <= df[NW:0];
                    q_reg[k+1]   <= {q_reg[k][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= tr[NW:0];
                    q_reg[k+1]   <= {q_reg[k][QB-2:0], 1'b0};
                end
            end
        end
    end
    assign out_valid = v_reg[QB];
    assign quot      = q_reg[QB][16:0];
endmodule

@@ sv/svcg_cordic.sv @@
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one registered micro-rotation per stage. Sideband rides along.
module svcg_cordic #(
    parameter int STAGES = 16,
    parameter int SBW    = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [33:0]  z_in,
    input  logic [SBW-1:0]      sb_in,
    output logic                out_valid,
    output logic signed [33:0]  x_out,
    output logic signed [33:0]  y_out,
    output logic [SBW-1:0]      sb_out
);
    import svcg_pkg::*;
    localparam logic signed [33:0] K0 =
        34'(GAIN_BASE + (GAIN_TAIL >> (2 * STAGES)));

    logic               v_reg  [STAGES+1];
    logic signed [33:0] x_reg  [STAGES+1];
    logic signed [33:0] y_reg  [STAGES+1];
    logic signed [33:0] z_reg  [STAGES+1];
    logic [SBW-1:0]     sb_reg [STAGES+1];

    assign v_reg[0]  = in_valid;
    assign x_reg[0]  = K0;
    assign y_reg[0]  = '0;
    assign z_reg[0]  = z_in;
    assign sb_reg[0] = sb_in;

    for (genvar k = 0; k < STAGES; k++) begin : g_rot
        logic signed [33:0] dx, dy;
        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k+1] <= sb_reg[k];
                if (!z_reg[k][33])
                begin
                    x_reg[k+1] <= x_reg[k] - dx;
                    y_reg[k+1] <= y_reg[k] + dy;
                    z_reg[k+1] <= z_reg[k] - atan_q30(k);
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + dx;
                    y_reg[k+1] <= y_reg[k] - dy;
                    z_reg[k+1] <= z_reg[k] + atan_q30(k);
                end
            end
        end
    end
    assign out_valid = v_reg[STAGES];
    assign x_out     = x_reg[STAGES];
    assign y_out     = y_reg[STAGES];
    assign sb_out    = sb_reg[STAGES];
endmodule

@@ sv/spiral_vertex_color_generator.sv @@
`timescale 1ns / 1ps
// Channel   | Dir | Payload
// vin       | in  | vertex_index[11:0]
// vout      | out | pos_x, pos_y (Q16.16), red/green/blue_level (Q1.16, 17b)
// cfg       | in  | cfg_we, cfg_index[1:0], cfg_data[23:0]
//
// One vertex per clock sustained while the output is taken. Pipeline stages, in order:
// 28 divider stages, 4 angle/radius/reduction stages, CORDIC_STAGES, 3 output stages.
// The whole pipeline advances when the output register is empty or taken, so a
// stall freezes every stage; nothing is lost or duplicated.
// Reset (rst_n, async low) clears valid bits and restores register defaults.
module spiral_vertex_color_generator #(
    parameter int MAX_VERTICES  = svcg_pkg::MAX_VERTICES_DEF,
    parameter int CORDIC_STAGES = svcg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [svcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [svcg_pkg::CFG_DATA_W-1:0] cfg_data,
    svcg_in_if.sink                      vin,
    svcg_out_if.source                   vout
);
    import svcg_pkg::*;

    localparam int NW = $clog2(MAX_VERTICES + 1);

    cfg_t cfg_reg;
    logic en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset    <= '0;
            cfg_reg.growth    <= 24'sd5243;
            cfg_reg.max_angle <= 24'd1647099;
            cfg_reg.count     <= 13'd600;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_OFFSET: cfg_reg.offset    <= $signed(cfg_data);
                REG_GROWTH: cfg_reg.growth    <= $signed(cfg_data);
                REG_MAXANG: cfg_reg.max_angle <= cfg_data;
                REG_COUNT:  cfg_reg.count     <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves together; stalls only when the output holds a result.
    assign en       = !vout.valid || vout.ready;
    assign vin.ready = en;

    // Clamp count and index
    logic [13:0] n_cl;
    logic [NW-1:0] nm1;
    logic [11:0] idx_cl;
    always_comb
    begin
        n_cl = {1'b0, cfg_reg.count};
        if (n_cl < 14'd2)
            n_cl = 14'd2;
        if (32'(n_cl) > MAX_VERTICES)
            n_cl = 14'(MAX_VERTICES);
        nm1 = NW'(n_cl - 14'd1);
        idx_cl = vin.vertex_index;
        if ({2'b0, vin.vertex_index} > 14'(nm1))
            idx_cl = 12'(nm1);
    end

    logic        dv_valid;
    logic [16:0] t16;
    svcg_divider #(.NW(NW)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(vin.valid && en),
        .idx(idx_cl), .dvs(nm1), .out_valid(dv_valid), .quot(t16)
    );

    // Stage A: angle product
    logic        a_v_reg;
    logic [16:0] a_t_reg;
    logic [40:0] a_prod_reg;
    // Stage B: radius product, angle
    logic        b_v_reg;
    logic [16:0] b_t_reg;
    logic [24:0] b_ang_reg;
    logic signed [50:0] b_gprod_reg;
    // Stage C: radius sum, quadrant estimate
    logic        c_v_reg;
    logic [16:0] c_t_reg;
    logic [40:0] c_a32_reg;
    logic signed [48:0] c_r_reg;
    // Stage D: remainder
    logic        d_v_reg;
    logic [16:0] d_t_reg;
    logic signed [48:0] d_r_reg;
    logic [1:0]  d_q_reg;
    logic signed [33:0] d_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= dv_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
        end
    end

    // Quadrant: a32 < 2^40 so q <= 162; find q via compares on a coarse
    // estimate: q_est = floor(a32 * recip) then correct by up to two.
    logic [40:0] c_a32_next;
    logic [7:0]  q_est;
    logic [48:0] qhp;
    logic [40:0] rem_try;
    logic [7:0]  q_fix;
    logic [40:0] rem_fix;
    // Register q estimate in stage C, fix in stage D.
    logic [7:0]  c_qe_reg;

    assign c_a32_next = {b_ang_reg[23:0], 16'd0};
    // reciprocal of HP in Q.48: 2^48/HP ~= 41721 (rounded down so estimate <= q)
    logic [56:0] est_prod;
    assign est_prod = 57'(c_a32_next) * 57'd41721;
    assign q_est = 8'(est_prod >> 48);

    assign qhp     = 49'(c_qe_reg) * 49'(HALF_PI_Q32);
    assign rem_try = 41'(49'(c_a32_reg) - qhp);
    always_comb
    begin
        q_fix   = c_qe_reg;
        rem_fix = rem_try;
        if (rem_fix >= 41'(HALF_PI_Q32))
        begin
            q_fix   = q_fix + 8'd1;
            rem_fix = rem_fix - 41'(HALF_PI_Q32);
        end
        if (rem_fix >= 41'(HALF_PI_Q32))
        begin
            q_fix   = q_fix + 8'd1;
            rem_fix = rem_fix - 41'(HALF_PI_Q32);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_t_reg     <= t16;
            a_prod_reg  <= 41'(t16) * 41'(cfg_reg.max_angle);
            b_t_reg     <= a_t_reg;
            b_ang_reg   <= 25'(a_prod_reg >> 16);
            b_gprod_reg <= 51'(cfg_reg.growth) * $signed({1'b0, 25'(a_prod_reg >> 16)});
            c_t_reg     <= b_t_reg;
            c_a32_reg   <= c_a32_next;
            c_qe_reg    <= q_est;
            c_r_reg     <= 49'(cfg_reg.offset) + 49'(b_gprod_reg >>> 16);
            d_t_reg     <= c_t_reg;
            d_r_reg     <= c_r_reg;
            d_q_reg     <= q_fix[1:0];
            d_z_reg     <= $signed({1'b0, 33'(rem_fix >> 2)});
        end
    end

    // CORDIC with sideband {t16, quad, r}
    localparam int SBW = 17 + 2 + 49;
    logic        k_v;
    logic signed [33:0] k_x, k_y;
    logic [SBW-1:0] k_sb;
    svcg_cordic #(.STAGES(CORDIC_STAGES), .SBW(SBW)) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_v_reg), .z_in(d_z_reg),
        .sb_in({d_t_reg, d_q_reg, d_r_reg}), .out_valid(k_v), .x_out(k_x),
        .y_out(k_y), .sb_out(k_sb)
    );

    logic [16:0] k_t;
    logic [1:0]  k_q;
    logic signed [48:0] k_r;
    assign {k_t, k_q, k_r} = k_sb;

    // Stage E: quadrant map, colour
    logic        e_v_reg;
    logic signed [48:0] e_r_reg;
    logic signed [33:0] e_c_reg, e_s_reg;
    logic [16:0] e_red_reg, e_grn_reg, e_blu_reg;
    logic signed [33:0] cm, sm;
    logic [19:0] h;
    logic [2:0]  seg;
    logic [16:0] f, g;
    logic [16:0] rr, gg, bb;

    always_comb
    begin
        unique case (k_q)
            2'd0: begin cm = k_x;  sm = k_y;  end
            2'd1: begin cm = -k_y; sm = k_x;  end
            2'd2: begin cm = -k_x; sm = -k_y; end
            default: begin cm = k_y; sm = -k_x; end
        endcase
        h   = 20'(k_t) * 20'd6;
        seg = h[18:16];
        f   = {1'b0, h[15:0]};
        if (seg >= 3'd6)
        begin
            seg = 3'd0;
            f   = '0;
        end
        g = 17'd65536 - f;
        unique case (seg)
            3'd0: begin rr = 17'd65536; gg = f; bb = '0; end
            3'd1: begin rr = g; gg = 17'd65536; bb = '0; end
            3'd2: begin rr = '0; gg = 17'd65536; bb = f; end
            3'd3: begin rr = '0; gg = g; bb = 17'd65536; end
            3'd4: begin rr = f; gg = '0; bb = 17'd65536; end
            default: begin rr = 17'd65536; gg = '0; bb = g; end
        endcase
    end

    // Stage F: products (r 49b x c 34b, split into two ~25x34 halves)
    logic        f_v_reg;
    logic [16:0] f_red_reg, f_grn_reg, f_blu_reg;
    logic signed [58:0] plx, ply;
    logic signed [58:0] phx, phy;
    assign plx = $signed({1'b0, e_r_reg[23:0]}) * e_c_reg;
    assign ply = $signed({1'b0, e_r_reg[23:0]}) * e_s_reg;
    assign phx = $signed(e_r_reg[48:24]) * e_c_reg;
    assign phy = $signed(e_r_reg[48:24]) * e_s_reg;
    logic signed [58:0] plx_reg, ply_reg, phx_reg, phy_reg;

    // Stage G: combine, shift, saturate into output register
    logic signed [82:0] fx, fy;
    logic signed [52:0] sx, sy;
    assign fx = (83'(phx_reg) <<< 24) + 83'(plx_reg);
    assign fy = (83'(phy_reg) <<< 24) + 83'(ply_reg);
    assign sx = 53'(fx >>> 30);
    assign sy = 53'(fy >>> 30);

    function automatic logic signed [31:0] sat32(input logic signed [52:0] v);
        if (v > 53'sd2147483647)
            return 32'sh7fffffff;
        if (v < -53'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    logic o_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            e_v_reg <= k_v;
            f_v_reg <= e_v_reg;
            o_v_reg <= f_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_r_reg   <= k_r;
            e_c_reg   <= cm;
            e_s_reg   <= sm;
            e_red_reg <= rr;
            e_grn_reg <= gg;
            e_blu_reg <= bb;
            plx_reg   <= plx;
            ply_reg   <= ply;
            phx_reg   <= phx;
            phy_reg   <= phy;
            f_red_reg <= e_red_reg;
            f_grn_reg <= e_grn_reg;
            f_blu_reg <= e_blu_reg;
            vout.pos_x       <= sat32(sx);
            vout.pos_y       <= sat32(sy);
            vout.red_level   <= f_red_reg;
            vout.green_level <= f_grn_reg;
            vout.blue_level  <= f_blu_reg;
        end
    end
    assign vout.valid = o_v_reg;
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
module tb;
    import svcg_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_reg_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    svcg_in_if vin ();
    svcg_out_if vout ();

    spiral_vertex_color_generator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .vin       (vin.sink),
        .vout      (vout.source)
    );

    // Settle margin for the pipeline to drain after the last expected result.
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [16:0]        r;
        logic [16:0]        g;
        logic [16:0]        b;
    } vertex_t;

    // Shadow copy of the block's registers.
    logic signed [23:0] sh_offset;
    logic signed [23:0] sh_growth;
    logic [23:0]        sh_max_angle;
    logic [12:0]        sh_count;

    vertex_t expected_vertices[$];
    int      errors;
    int      vertices_sent;
    int      vertices_checked;
    int      configs_done;

    // Stall control: random sink bursts, a long sink hold-off, or none; random source idling.
    bit      sink_random;
    bit      sink_hold_req;
    bit      source_random;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic signed [63:0] floor_div2(input logic signed [63:0] v,
                                                     input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [33:0] atan_entry(input int i);
        case (i)
            0:  return 34'sd843314857;
            1:  return 34'sd497837829;
            2:  return 34'sd263043837;
            3:  return 34'sd133525159;
            4:  return 34'sd67021687;
            5:  return 34'sd33543516;
            6:  return 34'sd16775851;
            7:  return 34'sd8388437;
            8:  return 34'sd4194283;
            9:  return 34'sd2097149;
            default: return (i < 24) ? (34'sd1048576 >>> (i - 10)) : 34'sd0;
        endcase
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'h7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Spiral position and rainbow color for one vertex index.
    function automatic vertex_t spiral_vertex(input logic [11:0] vidx);
        vertex_t v;
        longint unsigned n, idx, t16, angle, a32, quad, rem, h, f, g;
        longint r, x, y, z, c, s, nx, dx, dy;
        int seg;
        n = sh_count;
        if (n < 2)
            n = 2;
        if (n > MAX_VERTICES_DEF)
            n = MAX_VERTICES_DEF;
        idx = vidx;
        if (idx > n - 1)
            idx = n - 1;
        t16   = (idx << 16) / (n - 1);
        angle = (t16 * sh_max_angle) >> 16;
        r = longint'(sh_offset) + floor_div2(longint'(sh_growth) * longint'(angle), 16);
        a32  = angle << 16;
        quad = a32 / 64'd6746518852;
        rem  = a32 - quad * 64'd6746518852;
        z    = longint'(rem >> 2);
        x = 652032874 + (434688583 >> (2 * CORDIC_STAGES_DEF));
        y = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            dx = floor_div2(y, i);
            dy = floor_div2(x, i);
            if (z >= 0)
            begin
                nx = x - dx;
                y  = y + dy;
                z  = z - longint'(atan_entry(i));
            end
            else
            begin
                nx = x + dx;
                y  = y - dy;
                z  = z + longint'(atan_entry(i));
            end
            x = nx;
        end
        case (quad[1:0])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        v.x = clamp32(floor_div2(r * c, 30));
        v.y = clamp32(floor_div2(r * s, 30));
        h   = t16 * 6;
        seg = int'(h >> 16);
        f   = h & 64'hffff;
        // Hue at t = 1 lands on segment six; wrap it to pure red.
        if (seg >= 6)
        begin
            seg = 0;
            f   = 0;
        end
        g = 65536 - f;
        case (seg)
            0: begin v.r = 17'd65536; v.g = f[16:0];  v.b = 17'd0;     end
            1: begin v.r = g[16:0];   v.g = 17'd65536; v.b = 17'd0;     end
            2: begin v.r = 17'd0;     v.g = 17'd65536; v.b = f[16:0];  end
            3: begin v.r = 17'd0;     v.g = g[16:0];  v.b = 17'd65536; end
            4: begin v.r = f[16:0];   v.g = 17'd0;     v.b = 17'd65536; end
            default: begin v.r = 17'd65536; v.g = 17'd0; v.b = g[16:0]; end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %0h expected %0h (vertex %0d)", what, got, want,
                 vertices_checked);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [23:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (which)
            REG_OFFSET: sh_offset    = value;
            REG_GROWTH: sh_growth    = value;
            REG_MAXANG: sh_max_angle = value;
            default:    sh_count     = value[12:0];
        endcase
        configs_done++;
    endtask

    // Stops offering, then waits until every expected vertex has come back plus margin.
    task automatic wait_idle();
        vin.valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic configure(input logic [23:0] off, input logic [23:0] grow,
                             input logic [23:0] ang, input logic [12:0] cnt);
        wait_idle();
        write_reg(REG_OFFSET, off);
        write_reg(REG_GROWTH, grow);
        write_reg(REG_MAXANG, ang);
        write_reg(REG_COUNT, {11'd0, cnt});
    endtask

    // Offers one vertex index; prediction is queued on acceptance. Valid stays
    // high afterwards so the next transaction can follow in the next cycle.
    task automatic send_vertex(input logic [11:0] vidx);
        if (source_random && ($urandom_range(0, 3) == 0))
        begin
            vin.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        vin.valid        <= 1'b1;
        vin.vertex_index <= vidx;
        @(posedge clk);
        while (!vin.ready)
            @(posedge clk);
        expected_vertices = {expected_vertices, spiral_vertex(vidx)};
        vertices_sent++;
        @(negedge clk);
    endtask

    // Each transaction is sent back to back unless the source idles or the DUT stalls.
    task automatic send_burst(input logic [11:0] vidx);
        send_vertex(vidx);
    endtask

    function automatic logic [11:0] rand_index();
        int unsigned lim;
        lim = (sh_count < 2) ? 2 : ((sh_count > 4096) ? 4096 : sh_count);
        case ($urandom_range(0, 9))
            0: return 12'($urandom_range(0, 4095));
            1: return 12'(lim - 1);
            default: return 12'($urandom_range(0, lim - 1));
        endcase
    endfunction

    // Output checking: compare every accepted transaction with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && vout.valid && vout.ready)
        begin
            if (expected_vertices.size() == 0)
            begin
                report_mismatch("unexpected transaction", vout.pos_x, 32'd0);
            end
            else
            begin
                vertex_t want;
                want = expected_vertices.pop_front();
                if (vout.pos_x !== want.x)
                    report_mismatch("pos_x", vout.pos_x, want.x);
                if (vout.pos_y !== want.y)
                    report_mismatch("pos_y", vout.pos_y, want.y);
                if (vout.red_level !== want.r)
                    report_mismatch("red_level", 32'(vout.red_level), 32'(want.r));
                if (vout.green_level !== want.g)
                    report_mismatch("green_level", 32'(vout.green_level), 32'(want.g));
                if (vout.blue_level !== want.b)
                    report_mismatch("blue_level", 32'(vout.blue_level), 32'(want.b));
                vertices_checked++;
            end
        end
    end

    // Sink ready: random stall bursts, or a long counted hold-off on request.
    initial
    begin
        int burst;
        vout.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                vout.ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++)
                    @(negedge clk);
                sink_hold_req = 1'b0;
                vout.ready <= 1'b1;
            end
            else if (sink_random && ($urandom_range(0, 5) == 0))
            begin
                burst = $urandom_range(1, 16);
                vout.ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                vout.ready <= 1'b1;
        end
    end

    task automatic test_reset_defaults();
        // Registers at reset values; sweep both ends and the middle.
        send_burst(12'd0);
        send_burst(12'd1);
        send_burst(12'd299);
        send_burst(12'd599);
        send_burst(12'd4095);
    endtask

    task automatic test_extremes();
        // Largest radius and angle, saturating positions; count below range.
        configure(24'h7fffff, 24'h7fffff, 24'hffffff, 13'd0);
        send_burst(12'd0);
        send_burst(12'd1);
        send_burst(12'd4095);
        // Most negative offset and growth, count above range.
        configure(24'h800000, 24'h800000, 24'hffffff, 13'h1fff);
        send_burst(12'd0);
        send_burst(12'd2048);
        send_burst(12'd4095);
        send_burst(12'd4094);
        // Zero angle and count of exactly two.
        configure(24'h000000, 24'h000000, 24'h000000, 13'd2);
        send_burst(12'd0);
        send_burst(12'd1);
        send_burst(12'd7);
        // One segment boundary per hue step at N = 7.
        configure(24'h010000, 24'h002000, 24'h064000, 13'd7);
        for (int i = 0; i < 7; i++)
            send_burst(12'(i));
        send_burst(12'hfff);
    endtask

    task automatic test_random_configs();
        for (int p = 0; p < 6; p++)
        begin
            configure(24'($urandom), 24'($urandom), 24'($urandom),
                      13'($urandom_range(0, 8191)));
            for (int k = 0; k < 60; k++)
                send_burst(rand_index());
        end
    endtask

    task automatic test_backpressure();
        // Receiver holds off while the sender keeps offering, filling the pipe.
        configure(24'h004000, 24'h001000, 24'h0c8000, 13'd4096);
        sink_hold_req = 1'b1;
        for (int k = 0; k < 90; k++)
            send_burst(rand_index());
        // Sender pauses until all results are back.
        wait_idle();
        for (int k = 0; k < 20; k++)
            send_burst(rand_index());
    endtask

    task automatic test_full_rate();
        // No idling at the end: one transaction per clock both ways.
        wait_idle();
        sink_random   = 1'b0;
        source_random = 1'b0;
        for (int k = 0; k < 60; k++)
            send_burst(rand_index());
    endtask

    initial
    begin
        errors           = 0;
        vertices_sent    = 0;
        vertices_checked = 0;
        configs_done     = 0;
        sink_random      = 1'b1;
        source_random    = 1'b1;
        sink_hold_req    = 1'b0;
        sh_offset        = 24'sd0;
        sh_growth        = 24'sd5243;
        sh_max_angle     = 24'd1647099;
        sh_count         = 13'd600;
        cfg_we           = 1'b0;
        cfg_index        = REG_OFFSET;
        cfg_data         = '0;
        vin.valid        = 1'b0;
        vin.vertex_index = '0;
        rst_n            = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_extremes();
        test_random_configs();
        test_backpressure();
        test_full_rate();

        wait_idle();
        $display("Covered %0d vertices over %0d register writes, incl. stalls and wrap.",
                 vertices_checked, configs_done);
        if (errors == 0 && expected_vertices.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timeout waiting for results");
        $display("Some tests failed");
        $finish;
    end
endmodule
